[design/alr_pkg.sv]
// Shared types and constants for the audio loop recorder.
`default_nettype none
package alr_pkg;

   localparam int ALR_LOOP_DEPTH = 262144;
   localparam int SAMPLE_W       = 24;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 19;

   // -2.5 dB in Q0.16
   localparam logic signed [16:0] ATTEN_Q16 = 17'sd49145;

   localparam logic [15:0] OUT_GAIN_RST  = 16'd4096;
   localparam logic [15:0] FB_GAIN_RST   = 16'd16384;
   localparam logic [18:0] CAPACITY_RST  = 19'd262144;

   typedef enum logic [2:0] {
      CMD_FRAME   = 3'd0,
      CMD_RECORD  = 3'd1,
      CMD_PLAY    = 3'd2,
      CMD_ONCE    = 3'd3,
      CMD_STK_ON  = 3'd4,
      CMD_STK_OFF = 3'd5,
      CMD_REVERSE = 3'd6,
      CMD_THRU    = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_STOP = 2'd0,
      MODE_REC  = 2'd1,
      MODE_PLAY = 2'd2,
      MODE_DUB  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUT_GAIN = 2'd0,
      CSR_FB_GAIN  = 2'd1,
      CSR_CAPACITY = 2'd2,
      CSR_SPARE    = 2'd3
   } csr_idx_type;

endpackage
`default_nettype wire

[design/alr_ifs.sv]
// Valid/ready channel interfaces of the audio loop recorder.
`default_nettype none
interface alr_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          command;
   logic signed [23:0]  in_left;
   logic signed [23:0]  in_right;
   modport source(output valid, command, in_left, in_right, input ready);
   modport sink(input valid, command, in_left, in_right, output ready);
endinterface

interface alr_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [23:0]  out_left;
   logic signed [23:0]  out_right;
   logic [1:0]          mode_now;
   logic                wrapped;
   logic                once_done;
   logic                has_loop;
   modport source(output valid, out_left, out_right, mode_now, wrapped, once_done,
                  has_loop, input ready);
   modport sink(input valid, out_left, out_right, mode_now, wrapped, once_done,
                has_loop, output ready);
endinterface

interface alr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [18:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/audio_loop_recorder_unit.sv]
// Stereo loop recorder: loop memory, transport control and output mixing.
`default_nettype none
// One beat on req is either an audio frame or a button event; each beat gives
// exactly one rsp beat. Items are handled one at a time. A frame that reads the
// loop (play or overdub) passes through the accept cycle, two reads of the single
// read port of the loop memory (current and neighbor sample), a multiply stage,
// a mix/write-back stage, the output gain multiply and the round/saturate stage.
// Recording frames, pass-through frames and button events go from the accept
// cycle straight to the output gain multiply and the round/saturate stage. A new
// req beat is taken while a result still waits on rsp; that item then holds in
// its last stage until the waiting beat leaves. The loop memory needs no
// clearing after reset; csr writes are always taken and must come while idle.
module audio_loop_recorder_unit
   import alr_pkg::*;
#(
   parameter int LOOP_DEPTH = ALR_LOOP_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   alr_req_if.sink   req_bus,
   alr_rsp_if.source rsp_bus,
   alr_csr_if.sink   csr_bus
);

   localparam int AW = $clog2(LOOP_DEPTH);
   localparam int LW = AW + 1;
   localparam int PW = AW + 2;
   localparam int V2W = 27;
   localparam logic [LW-1:0] CAP_RST =
      (LOOP_DEPTH < 262144) ? LW'(LOOP_DEPTH) : LW'(CAPACITY_RST);

   typedef enum logic [2:0] {
      S_IDLE, S_RDA, S_RDB, S_MUL, S_MIX, S_GAIN, S_OUT
   } state_type;

   typedef enum logic [1:0] {K_PASS, K_PLAY, K_DUB} kind_type;

   function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
      if (v > 44'sd8388607) return 24'sh7FFFFF;
      if (v < -44'sd8388608) return 24'sh800000;
      return v[23:0];
   endfunction

   // control and configuration registers
   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   logic [PW-1:0]   pp_ff, pp_in, rp_ff, rp_in;
   logic [LW-1:0]   len_ff, len_in, cap_ff, cap_in;
   logic            has_ff, has_in, rev_ff, rev_in, half_ff, half_in;
   logic            once_ff, once_in, thru_ff, thru_in, stack_ff, stack_in;
   logic [15:0]     ogain_ff, ogain_in, fbgain_ff, fbgain_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // per-item registers
   kind_type              kind_ff, kind_in;
   logic [AW-1:0]         pa_ff, pa_in, oa_ff, oa_in;
   logic                  odd_ff, odd_in, wrap_ff, wrap_in, done_ff, done_in;
   mode_type              mnow_ff, mnow_in;
   logic                  hnow_ff, hnow_in;
   logic signed [23:0]    x_ff [2];
   logic signed [23:0]    a_ff [2];
   logic signed [40:0]    oprod_ff [2];
   logic signed [40:0]    iprod_ff [2];
   logic signed [24:0]    psum_ff [2];
   logic signed [V2W-1:0] v2_ff [2];
   logic signed [V2W-1:0] v2_in [2];
   logic signed [43:0]    gp_ff [2];
   logic signed [23:0]    ol_ff, or_ff;
   logic [1:0]            omode_ff;
   logic                  owrap_ff, odone_ff, ohas_ff;

   // loop memory
   logic [47:0]     mem [LOOP_DEPTH];
   logic [47:0]     mem_rd_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_wa, mem_ra;
   logic [47:0]     mem_wd;
   logic            rec_we;
   logic [AW-1:0]   rec_wa;

   logic            accept, out_free;
   logic signed [23:0] nv [2];
   logic signed [23:0] rd_b [2];
   logic signed [16:0] ogain_s, fbgain_s;
   logic [PW-1:0]   step, span, fwd_pos;
   logic [LW-1:0]   w_idx, p_idx, len_stop;
   logic            has_stop;
   logic [18:0]     cap_req;

   assign accept      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign ogain_s     = $signed({1'b0, ogain_ff});
   assign fbgain_s    = $signed({1'b0, fbgain_ff});
   assign rd_b[0]     = $signed(mem_rd_ff[23:0]);
   assign rd_b[1]     = $signed(mem_rd_ff[47:24]);

   assign step     = half_ff ? PW'(1) : PW'(2);
   assign span     = {len_ff, 1'b0};
   assign fwd_pos  = pp_ff + step;
   assign w_idx    = rp_ff[PW-1:1];
   assign p_idx    = pp_ff[PW-1:1];
   assign len_stop = rp_ff[PW-1:1];
   assign has_stop = (len_stop != '0);
   assign cap_req  = csr_bus.data;

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         nv[c] = sat24(44'(oprod_ff[c]) + (44'(iprod_ff[c]) <<< 2) + 44'sd32768 >>> 16);
      end
   end

   // transport control, evaluated at accept
   always_comb begin
      mode_in  = mode_ff;
      pp_in    = pp_ff;
      rp_in    = rp_ff;
      len_in   = len_ff;
      has_in   = has_ff;
      rev_in   = rev_ff;
      half_in  = half_ff;
      once_in  = once_ff;
      thru_in  = thru_ff;
      stack_in = stack_ff;
      kind_in  = K_PASS;
      pa_in    = p_idx[AW-1:0];
      oa_in    = p_idx[AW-1:0];
      odd_in   = pp_ff[0];
      wrap_in  = 1'b0;
      done_in  = 1'b0;
      rec_we   = 1'b0;
      rec_wa   = w_idx[AW-1:0];
      for (int c = 0; c < 2; c++) v2_in[c] = '0;
      if (accept) begin
         case (cmd_type'(req_bus.command))
            CMD_FRAME: begin
               if (mode_ff == MODE_STOP || mode_ff == MODE_REC ||
                   (mode_ff == MODE_DUB && (!has_ff || len_ff == '0))) begin
                  if (mode_ff != MODE_STOP) begin
                     if (w_idx >= cap_ff) begin
                        len_in  = len_stop;
                        has_in  = has_stop;
                        mode_in = MODE_STOP;
                     end else begin
                        rec_we = 1'b1;
                        rp_in  = rp_ff + step;
                     end
                  end
                  if (!thru_ff) begin
                     v2_in[0] = V2W'(req_bus.in_left) <<< 1;
                     v2_in[1] = V2W'(req_bus.in_right) <<< 1;
                  end
               end else if (has_ff && len_ff != '0) begin
                  kind_in = (mode_ff == MODE_DUB || stack_ff) ? K_DUB : K_PLAY;
                  if (rev_ff) begin
                     oa_in = (p_idx != '0) ? AW'(p_idx - 1'b1) : AW'(len_ff - 1'b1);
                     if (pp_ff < step) begin
                        pp_in   = pp_ff + span - step;
                        wrap_in = 1'b1;
                     end else begin
                        pp_in = pp_ff - step;
                     end
                  end else begin
                     oa_in = (LW'(p_idx + 1'b1) == len_ff) ? '0 : AW'(p_idx + 1'b1);
                     if (fwd_pos >= span) begin
                        pp_in   = '0;
                        wrap_in = 1'b1;
                     end else begin
                        pp_in = fwd_pos;
                     end
                  end
                  if (wrap_in && once_ff) begin
                     mode_in = MODE_STOP;
                     once_in = 1'b0;
                     done_in = 1'b1;
                  end
               end
            end
            CMD_RECORD: begin
               case (mode_ff)
                  MODE_STOP, MODE_PLAY: begin
                     rp_in   = '0;
                     mode_in = MODE_REC;
                  end
                  MODE_REC: begin
                     len_in  = len_stop;
                     has_in  = has_stop;
                     mode_in = has_stop ? MODE_PLAY : MODE_STOP;
                     if (has_stop) pp_in = rev_ff ? {len_stop - 1'b1, 1'b0} : '0;
                  end
                  default: begin
                     mode_in  = MODE_PLAY;
                     stack_in = 1'b0;
                  end
               endcase
            end
            CMD_PLAY: begin
               case (mode_ff)
                  MODE_STOP: begin
                     if (has_ff && len_ff != '0) begin
                        mode_in = MODE_PLAY;
                        pp_in   = rev_ff ? {len_ff - 1'b1, 1'b0} : '0;
                     end
                  end
                  MODE_REC: begin
                     len_in  = len_stop;
                     has_in  = has_stop;
                     mode_in = MODE_STOP;
                  end
                  default: mode_in = MODE_STOP;
               endcase
            end
            CMD_ONCE: begin
               case (mode_ff)
                  MODE_PLAY: begin
                     if (!once_ff) begin
                        once_in = 1'b1;
                     end else begin
                        mode_in = (has_ff && len_ff != '0) ? MODE_PLAY : MODE_STOP;
                        pp_in   = rev_ff ? {len_ff - 1'b1, 1'b0} : '0;
                     end
                  end
                  MODE_REC: begin
                     len_in  = len_stop;
                     has_in  = has_stop;
                     once_in = 1'b1;
                     mode_in = has_stop ? MODE_PLAY : MODE_STOP;
                     if (has_stop) pp_in = rev_ff ? {len_stop - 1'b1, 1'b0} : '0;
                  end
                  MODE_STOP: begin
                     once_in = 1'b1;
                     if (has_ff && len_ff != '0) begin
                        mode_in = MODE_PLAY;
                        pp_in   = rev_ff ? {len_ff - 1'b1, 1'b0} : '0;
                     end
                  end
                  default: ;
               endcase
            end
            CMD_STK_ON: begin
               if (mode_ff == MODE_PLAY && has_ff) begin
                  mode_in  = MODE_DUB;
                  stack_in = 1'b1;
               end else if (mode_ff == MODE_STOP) begin
                  half_in = !half_ff;
               end
            end
            CMD_STK_OFF: begin
               if (mode_ff == MODE_DUB) begin
                  mode_in  = MODE_PLAY;
                  stack_in = 1'b0;
               end
            end
            // the play position is re-seeded on every entry to playback, so an
            // out-of-range position left by a shorter recording is never read
            CMD_REVERSE: rev_in = !rev_ff;
            CMD_THRU:    thru_in = !thru_ff;
            default: ;
         endcase
      end
   end

   assign mnow_in = mode_in;
   assign hnow_in = has_in;

   always_comb begin
      ogain_in  = ogain_ff;
      fbgain_in = fbgain_ff;
      cap_in    = cap_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_idx_type'(csr_bus.index))
            CSR_OUT_GAIN: ogain_in  = csr_bus.data[15:0];
            CSR_FB_GAIN:  fbgain_in = csr_bus.data[15:0];
            CSR_CAPACITY: cap_in = (32'(cap_req) > 32'(LOOP_DEPTH)) ?
                                   LW'(LOOP_DEPTH) : LW'(cap_req);
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (kind_in == K_PASS) ? S_GAIN : S_RDA;
         end
         S_RDA:  state_in = S_RDB;
         S_RDB:  state_in = S_MUL;
         S_MUL:  state_in = S_MIX;
         S_MIX:  state_in = S_GAIN;
         S_GAIN: state_in = S_OUT;
         S_OUT: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port: record write at accept, overdub write-back in mix stage
   always_comb begin
      mem_we = rec_we;
      mem_wa = rec_wa;
      mem_wd = {req_bus.in_right, req_bus.in_left};
      mem_ra = (state_ff == S_RDB) ? oa_ff : pa_ff;
      if (state_ff == S_MIX && kind_ff == K_DUB) begin
         mem_we = 1'b1;
         mem_wa = pa_ff;
         mem_wd = {nv[1], nv[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_STOP;
         pp_ff        <= '0;
         rp_ff        <= '0;
         len_ff       <= '0;
         has_ff       <= 1'b0;
         rev_ff       <= 1'b0;
         half_ff      <= 1'b0;
         once_ff      <= 1'b0;
         thru_ff      <= 1'b0;
         stack_ff     <= 1'b0;
         ogain_ff     <= OUT_GAIN_RST;
         fbgain_ff    <= FB_GAIN_RST;
         cap_ff       <= CAP_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pp_ff        <= pp_in;
         rp_ff        <= rp_in;
         len_ff       <= len_in;
         has_ff       <= has_in;
         rev_ff       <= rev_in;
         half_ff      <= half_in;
         once_ff      <= once_in;
         thru_ff      <= thru_in;
         stack_ff     <= stack_in;
         ogain_ff     <= ogain_in;
         fbgain_ff    <= fbgain_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         kind_ff  <= kind_in;
         pa_ff    <= pa_in;
         oa_ff    <= oa_in;
         odd_ff   <= odd_in;
         wrap_ff  <= wrap_in;
         done_ff  <= done_in;
         mnow_ff  <= mnow_in;
         hnow_ff  <= hnow_in;
         x_ff[0]  <= req_bus.in_left;
         x_ff[1]  <= req_bus.in_right;
         v2_ff    <= v2_in;
      end
      if (state_ff == S_RDB) begin
         a_ff[0] <= rd_b[0];
         a_ff[1] <= rd_b[1];
      end
      if (state_ff == S_MUL) begin
         for (int c = 0; c < 2; c++) begin
            oprod_ff[c] <= a_ff[c] * ATTEN_Q16;
            iprod_ff[c] <= x_ff[c] * fbgain_s;
            psum_ff[c]  <= odd_ff ? 25'(a_ff[c]) + 25'(rd_b[c]) : 25'(a_ff[c]) <<< 1;
         end
      end
      if (state_ff == S_MIX) begin
         for (int c = 0; c < 2; c++) begin
            if (kind_ff == K_DUB) begin
               v2_ff[c] <= thru_ff ? V2W'(nv[c]) <<< 1
                                   : (V2W'(nv[c]) + V2W'(x_ff[c])) <<< 1;
            end else begin
               v2_ff[c] <= thru_ff ? V2W'(psum_ff[c])
                                   : V2W'(psum_ff[c]) + (V2W'(x_ff[c]) <<< 1);
            end
         end
      end
      if (state_ff == S_GAIN) begin
         for (int c = 0; c < 2; c++) gp_ff[c] <= v2_ff[c] * ogain_s;
      end
      if (state_ff == S_OUT && out_free) begin
         ol_ff    <= sat24((gp_ff[0] + 44'sd4096) >>> 13);
         or_ff    <= sat24((gp_ff[1] + 44'sd4096) >>> 13);
         omode_ff <= mnow_ff;
         owrap_ff <= wrap_ff;
         odone_ff <= done_ff;
         ohas_ff  <= hnow_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_left  = ol_ff;
   assign rsp_bus.out_right = or_ff;
   assign rsp_bus.mode_now  = omode_ff;
   assign rsp_bus.wrapped   = owrap_ff;
   assign rsp_bus.once_done = odone_ff;
   assign rsp_bus.has_loop  = ohas_ff;

endmodule
`default_nettype wire

[design/alr_checker.sv]
// Port-level checks for the audio loop recorder, bound to the top level.
`default_nettype none
module alr_checker
   import alr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_mode_now,
   input wire logic       rsp_wrapped,
   input wire logic       rsp_once_done,
   input wire logic [47:0] rsp_samples
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_samples))
      else $error("rsp beat changed while stalled");

   // one item at a time: no new beat right after one is taken
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while an item is in flight");

   // once mode ends only on a wrap, and leaves the block stopped
   a_once_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_once_done |-> rsp_wrapped && rsp_mode_now == MODE_STOP)
      else $error("once_done without wrap or stop");

   a_no_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind audio_loop_recorder_unit alr_checker u_alr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_mode_now  (rsp_bus.mode_now),
   .rsp_wrapped   (rsp_bus.wrapped),
   .rsp_once_done (rsp_bus.once_done),
   .rsp_samples   ({rsp_bus.out_right, rsp_bus.out_left})
);
`default_nettype wire

[tb/sv/alr_scoreboard.sv]
// Checker for the audio loop recorder: watches the channels, predicts results and compares.
`timescale 1ns / 1ps
module alr_scoreboard
   import alr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   alr_req_if        req,
   alr_rsp_if        rsp,
   alr_csr_if        csr,
   output int        fail_count,
   output int        pending_count
);

   typedef struct packed {
      logic signed [23:0] left;
      logic signed [23:0] right;
      logic [1:0]         mode;
      logic               wrap;
      logic               done;
      logic               loaded;
   } frame_result_type;

   frame_result_type expected_results[$];

   logic signed [23:0] loop_mem [ALR_LOOP_DEPTH][2];
   int unsigned play_pos, rec_pos, loop_len;
   bit          has_content, reverse_on, half_on, once_on, thru_on, stack_on;
   mode_type    mode;
   logic [15:0] out_gain, fb_gain;
   logic [18:0] capacity;

   function automatic longint sat24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // floor((v + 2^(k-1)) / 2^k)
   function automatic longint round_down(longint v, int k);
      return (v + (64'sd1 <<< (k - 1))) >>> k;
   endfunction

   function automatic void end_recording();
      loop_len = rec_pos >> 1;
      if (loop_len > ALR_LOOP_DEPTH) loop_len = ALR_LOOP_DEPTH;
      has_content = loop_len > 0;
      mode = MODE_STOP;
   endfunction

   function automatic void begin_playback();
      if (has_content && loop_len > 0) begin
         play_pos = reverse_on ? 2 * (loop_len - 1) : 0;
         mode = MODE_PLAY;
      end
   endfunction

   function automatic void capture_frame(longint l, longint r);
      int unsigned lim, w;
      lim = (capacity > ALR_LOOP_DEPTH) ? ALR_LOOP_DEPTH : capacity;
      w = rec_pos >> 1;
      if (w >= lim) begin
         end_recording();
         return;
      end
      loop_mem[w][0] = l[23:0];
      loop_mem[w][1] = r[23:0];
      rec_pos += half_on ? 1 : 2;
   endfunction

   function automatic bit advance_play();
      int unsigned stride, span;
      stride = half_on ? 1 : 2;
      span = 2 * loop_len;
      if (reverse_on) begin
         if (play_pos < stride) begin
            play_pos = play_pos + span - stride;
            return 1;
         end
         play_pos -= stride;
         return 0;
      end
      play_pos += stride;
      if (play_pos >= span) begin
         play_pos = 0;
         return 1;
      end
      return 0;
   endfunction

   function automatic frame_result_type mix_item(cmd_type cmd, logic signed [23:0] il,
                                                 logic signed [23:0] ir);
      longint           x[2], v2[2], nv, s;
      bit               wrap, done, loaded;
      int unsigned      p, other;
      frame_result_type res;
      x[0] = il;
      x[1] = ir;
      v2[0] = 0;
      v2[1] = 0;
      wrap = 0;
      done = 0;
      loaded = has_content && loop_len > 0;
      case (cmd)
         CMD_FRAME: begin
            v2[0] = 2 * x[0];
            v2[1] = 2 * x[1];
            if (mode == MODE_STOP || mode == MODE_REC || (mode == MODE_DUB && !loaded)) begin
               if (mode != MODE_STOP) capture_frame(x[0], x[1]);
               if (thru_on) begin
                  v2[0] = 0;
                  v2[1] = 0;
               end
            end else if (!loaded) begin
               v2[0] = 0;
               v2[1] = 0;
            end else begin
               p = play_pos >> 1;
               if (mode == MODE_DUB || stack_on) begin
                  for (int c = 0; c < 2; c++) begin
                     nv = sat24(round_down(longint'(loop_mem[p][c]) * 49145 +
                                           x[c] * longint'(fb_gain) * 4, 16));
                     loop_mem[p][c] = nv[23:0];
                     v2[c] = thru_on ? 2 * nv : 2 * (nv + x[c]);
                  end
               end else begin
                  if (reverse_on) other = (p > 0) ? p - 1 : loop_len - 1;
                  else other = (p + 1) % loop_len;
                  for (int c = 0; c < 2; c++) begin
                     s = play_pos[0] ? longint'(loop_mem[p][c]) + loop_mem[other][c]
                                     : 2 * longint'(loop_mem[p][c]);
                     v2[c] = thru_on ? s : s + 2 * x[c];
                  end
               end
               wrap = advance_play();
               if (wrap && once_on) begin
                  mode = MODE_STOP;
                  once_on = 0;
                  done = 1;
               end
            end
         end
         CMD_RECORD: begin
            if (mode == MODE_STOP || mode == MODE_PLAY) begin
               rec_pos = 0;
               mode = MODE_REC;
            end else if (mode == MODE_REC) begin
               end_recording();
               begin_playback();
            end else begin
               mode = MODE_PLAY;
               stack_on = 0;
            end
         end
         CMD_PLAY: begin
            if (mode == MODE_STOP) begin_playback();
            else if (mode == MODE_REC) end_recording();
            else mode = MODE_STOP;
         end
         CMD_ONCE: begin
            if (mode == MODE_PLAY) begin
               if (!once_on) once_on = 1;
               else begin
                  mode = MODE_STOP;
                  begin_playback();
               end
            end else if (mode == MODE_STOP || mode == MODE_REC) begin
               if (mode == MODE_REC) end_recording();
               once_on = 1;
               begin_playback();
            end
         end
         CMD_STK_ON: begin
            if (mode == MODE_PLAY) begin
               if (has_content) begin
                  mode = MODE_DUB;
                  stack_on = 1;
               end
            end else if (mode == MODE_STOP) begin
               half_on = !half_on;
            end
         end
         CMD_STK_OFF: begin
            if (mode == MODE_DUB) begin
               mode = MODE_PLAY;
               stack_on = 0;
            end
         end
         CMD_REVERSE: begin
            reverse_on = !reverse_on;
            if (loop_len > 0 && play_pos >= 2 * loop_len) play_pos %= 2 * loop_len;
         end
         default: thru_on = !thru_on;
      endcase
      if (cmd == CMD_FRAME) begin
         nv = sat24(round_down(v2[0] * longint'(out_gain), 13));
         res.left = nv[23:0];
         nv = sat24(round_down(v2[1] * longint'(out_gain), 13));
         res.right = nv[23:0];
      end else begin
         res.left = '0;
         res.right = '0;
      end
      res.mode = mode;
      res.wrap = wrap;
      res.done = done;
      res.loaded = has_content;
      return res;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         expected_results.delete();
         fail_count = 0;
         play_pos = 0;
         rec_pos = 0;
         loop_len = 0;
         {has_content, reverse_on, half_on, once_on, thru_on, stack_on} = '0;
         mode = MODE_STOP;
         out_gain = OUT_GAIN_RST;
         fb_gain = FB_GAIN_RST;
         capacity = CAPACITY_RST;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr_idx_type'(csr.index))
               CSR_OUT_GAIN: out_gain = csr.data[15:0];
               CSR_FB_GAIN:  fb_gain = csr.data[15:0];
               CSR_CAPACITY: capacity = csr.data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result beats outstanding", 1, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp.out_left !== want.left)
                  report_mismatch("out_left", rsp.out_left, want.left);
               if (rsp.out_right !== want.right)
                  report_mismatch("out_right", rsp.out_right, want.right);
               if (rsp.mode_now !== want.mode) report_mismatch("mode_now", rsp.mode_now, want.mode);
               if (rsp.wrapped !== want.wrap) report_mismatch("wrapped", rsp.wrapped, want.wrap);
               if (rsp.once_done !== want.done)
                  report_mismatch("once_done", rsp.once_done, want.done);
               if (rsp.has_loop !== want.loaded)
                  report_mismatch("has_loop", rsp.has_loop, want.loaded);
            end
         end
         if (req.valid && req.ready)
            expected_results.push_back(mix_item(cmd_type'(req.command), req.in_left, req.in_right));
      end
      pending_count = expected_results.size();
   end

endmodule

[tb/sv/audio_loop_recorder_unit_tb.sv]
// Top of the audio loop recorder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module audio_loop_recorder_unit_tb;
   import alr_pkg::*;

   localparam int PHASES         = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int CYCLE_LIMIT    = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   cycle_count = 0;
   int   items_sent = 0;
   bit   calm = 0;
   bit   hold_request = 0;

   alr_req_if req_bus();
   alr_rsp_if rsp_bus();
   alr_csr_if csr_bus();

   audio_loop_recorder_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   alr_scoreboard scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .csr          (csr_bus),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      int r;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (200) @(posedge clock);
         end else if (calm) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_bus.ready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_bus.ready <= 1'b0;
               repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clock);
            end
         end
      end
   end

   task automatic send_item(cmd_type cmd, logic [23:0] left, logic [23:0] right);
      int r, gap;
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.in_left <= left;
      req_bus.in_right <= right;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      r = $urandom_range(0, 99);
      gap = (calm || r < 70) ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 30));
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_frame();
      send_item(CMD_FRAME, $urandom, $urandom);
   endtask

   // wait for the next clock edge first so that the last accepted beat is already counted
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [18:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) send_frame();
      else send_item(cmd_type'($urandom_range(1, 7)), $urandom, $urandom);
   endtask

   // Record a short loop with random content, then close it one of several ways.
   task automatic take_loop();
      int n, r;
      send_item(CMD_RECORD, $urandom, $urandom);
      n = $urandom_range(1, 30);
      repeat (n) send_frame();
      r = $urandom_range(0, 3);
      case (r)
         0: send_item(CMD_PLAY, $urandom, $urandom);
         1: send_item(CMD_ONCE, $urandom, $urandom);
         default: send_item(CMD_RECORD, $urandom, $urandom);
      endcase
      repeat ($urandom_range(5, 60)) begin
         if ($urandom_range(0, 9) < 8) send_frame();
         else send_item(cmd_type'($urandom_range(3, 7)), $urandom, $urandom);
      end
   endtask

   initial begin
      logic [15:0] gain;
      logic [15:0] fb;
      logic [18:0] cap;
      bit          mid_done;
      req_bus.valid <= 1'b0;
      req_bus.command <= CMD_FRAME;
      req_bus.in_left <= '0;
      req_bus.in_right <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_OUT_GAIN;
      csr_bus.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, thru-mute, record, once, reverse, overdub, stale stack
      calm = 1;
      send_item(CMD_FRAME, 24'h7FFFFF, 24'h800000);
      send_item(CMD_THRU, '0, '0);
      send_item(CMD_FRAME, 24'h800000, 24'h7FFFFF);
      send_item(CMD_THRU, '0, '0);
      send_item(CMD_PLAY, '0, '0);
      send_item(CMD_RECORD, '0, '0);
      send_item(CMD_FRAME, 24'h7FFFFF, 24'h800000);
      send_item(CMD_FRAME, 24'h800000, 24'h7FFFFF);
      send_item(CMD_FRAME, 24'h123456, 24'hABCDEF);
      send_item(CMD_RECORD, '0, '0);
      repeat (4) send_frame();
      send_item(CMD_ONCE, '0, '0);
      repeat (3) send_frame();
      send_item(CMD_REVERSE, '0, '0);
      send_item(CMD_PLAY, '0, '0);
      send_frame();
      send_item(CMD_STK_ON, '0, '0);
      send_item(CMD_FRAME, 24'h7FFFFF, 24'h7FFFFF);
      send_item(CMD_STK_OFF, '0, '0);
      send_item(CMD_STK_ON, '0, '0);
      send_item(CMD_PLAY, '0, '0);
      send_item(CMD_PLAY, '0, '0);
      send_frame();
      send_item(CMD_PLAY, '0, '0);
      send_item(CMD_STK_ON, '0, '0);
      calm = 0;

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         case (phase % 4)
            0: begin gain = 16'd0;     fb = 16'd32768; cap = 19'd1;      end
            1: begin gain = 16'd65535; fb = 16'd0;     cap = 19'd262144; end
            2: begin gain = 16'd4096;  fb = 16'd16384; cap = $urandom_range(2, 24); end
            default: begin
               gain = $urandom;
               fb = $urandom_range(0, 32768);
               cap = $urandom_range(1, 262144);
            end
         endcase
         write_reg(CSR_OUT_GAIN, {3'b0, gain});
         write_reg(CSR_FB_GAIN, {3'b0, fb});
         write_reg(CSR_CAPACITY, cap);
         calm = (phase == 1);
         mid_done = 0;
         for (int k = items_sent + ITEMS_PER_PHASE; items_sent < k;) begin
            // halfway through: long receiver hold-off, or a full drain
            if (!mid_done && items_sent + ITEMS_PER_PHASE / 2 >= k) begin
               mid_done = 1;
               if (phase == 2) hold_request = 1;
               if (phase == 3) drain_results();
            end
            if ($urandom_range(0, 99) < 15) take_loop();
            else random_item();
         end
      end

      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("sent %0d items over %0d register settings", items_sent, PHASES);
      $display("with loop recording, playback, overdub, reverse and once mode exercised");
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
